// ===== sv/keyframe_linear_interpolator_defines.svh =====
// Assertion macros for the keyframe interpolator checker.
// Included by the checker file only.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KLI_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("kli check failed");
`define KLI_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("kli check failed");
`endif

// ===== sv/kli_pkg.sv =====
// Package for the keyframe interpolator: mode and status codes, command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kli_pkg;
  localparam int NUM_VALUES = 9;
  localparam int POS_W = 24;
  localparam int IN_W = 32;
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;
  localparam logic [1:0] ST_SAMPLED = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;
  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_SRCH_LD, OP_SHIFT, OP_WRITE, OP_LOAD_LO, OP_LOAD_HI,
    OP_DIV, OP_INTERP, OP_COPY, OP_ZERO
  } op_t;
  typedef struct packed {
    op_t op;
  } cmd_t;
  typedef struct packed {
    logic empty;
    logic full;
    logic srch_done;
    logic shift_done;
    logic div_done;
    logic interp_done;
    logic below_first;
    logic above_last;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/kli_datapath.sv =====
// Datapath: keyframe table, search pointer, divider and interpolation unit.
// Depends on kli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kli_datapath #(
  parameter int MAX_KEYFRAMES = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire kli_pkg::cmd_t cmd,
  output kli_pkg::stat_t stat,
  input  wire logic [kli_pkg::POS_W-1:0] in_pos,
  input  wire logic [kli_pkg::NUM_VALUES*kli_pkg::IN_W-1:0] in_vals,
  output logic [kli_pkg::NUM_VALUES*kli_pkg::IN_W-1:0] res_vals
);
  import kli_pkg::*;
  localparam int IW = $clog2(MAX_KEYFRAMES);
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int SW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DW = VALUE_BITS + 1;
  localparam int PW = DW + 18;
  typedef logic signed [VALUE_BITS-1:0] val_t;

  logic [POS_W-1:0] pos_mem [MAX_KEYFRAMES];
  val_t             val_mem [MAX_KEYFRAMES][NUM_VALUES];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] ptr_r;
  logic [POS_W-1:0] f_r;
  val_t vin_r [NUM_VALUES];
  val_t a_r [NUM_VALUES];
  val_t b_r [NUM_VALUES];
  val_t v_r [NUM_VALUES];
  logic [POS_W-1:0] plo_r, phi_r;
  logic [40:0] rem_r;
  logic [16:0] q_r;
  logic [5:0] dcnt_r;
  logic [3:0] jcnt_r;
  logic signed [PW-1:0] prod_r;

  logic [IW-1:0] pi, pim1, last_i;
  assign pi = ptr_r[IW-1:0];
  assign pim1 = IW'(ptr_r - CW'(1));
  assign last_i = IW'(cnt_r - CW'(1));

  assign stat.empty = (cnt_r == '0);
  assign stat.full = (cnt_r == CW'(MAX_KEYFRAMES));
  assign stat.below_first = (cnt_r == CW'(1)) || (f_r <= pos_mem[0]);
  assign stat.above_last = (f_r >= pos_mem[last_i]);
  assign stat.shift_done = (ptr_r == '0) || (pos_mem[pim1] <= f_r);
  assign stat.srch_done = (ptr_r >= cnt_r - CW'(1)) || !(pos_mem[pi] < f_r);
  assign stat.div_done = (dcnt_r == 6'd17);
  assign stat.interp_done = (jcnt_r == 4'(NUM_VALUES));

  logic [40:0] trial;
  logic [24:0] dsr;
  assign dsr = {1'b0, phi_r - plo_r};
  assign trial = {rem_r[39:0], 1'b0};

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic [3:0] jj;
  assign jj = (jcnt_r < 4'(NUM_VALUES)) ? jcnt_r : 4'd0;
  assign diff = DW'(b_r[jj]) - DW'(a_r[jj]);
  assign prod = PW'(diff) * PW'(signed'({1'b0, q_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: cnt_r <= '0;
        OP_WRITE: cnt_r <= cnt_r + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SRCH_LD: begin
        f_r <= in_pos;
        ptr_r <= cnt_r;
        jcnt_r <= '0;
        dcnt_r <= '0;
        for (int j = 0; j < NUM_VALUES; j++) begin
          v_r[j] <= '0;
          vin_r[j] <= VALUE_BITS'(signed'(in_vals[j*IN_W +: SW]));
        end
      end
      OP_CLEAR, OP_ZERO: for (int j = 0; j < NUM_VALUES; j++) v_r[j] <= '0;
      OP_SHIFT: begin
        pos_mem[pi] <= pos_mem[pim1];
        for (int j = 0; j < NUM_VALUES; j++) val_mem[pi][j] <= val_mem[pim1][j];
        ptr_r <= ptr_r - CW'(1);
      end
      OP_WRITE: begin
        pos_mem[pi] <= f_r;
        for (int j = 0; j < NUM_VALUES; j++)
          val_mem[pi][j] <= vin_r[j];
      end
      OP_LOAD_LO: ptr_r <= CW'(1);
      OP_LOAD_HI: begin
        if (!stat.srch_done) ptr_r <= ptr_r + CW'(1);
        else begin
          plo_r <= pos_mem[pim1];
          phi_r <= pos_mem[pi];
          for (int j = 0; j < NUM_VALUES; j++) begin
            a_r[j] <= val_mem[pim1][j];
            b_r[j] <= val_mem[pi][j];
          end
          rem_r <= {2'b0, f_r - pos_mem[pim1], 15'd0};
          q_r <= '0;
        end
      end
      OP_DIV: begin
        dcnt_r <= dcnt_r + 6'd1;
        if (dcnt_r == 6'd0) rem_r <= rem_r;
        if (trial[40:16] >= dsr) begin
          rem_r <= {trial[40:16] - dsr, trial[15:0]};
          q_r <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r <= {q_r[15:0], 1'b0};
        end
      end
      OP_INTERP: begin
        if (dcnt_r != 6'd18) begin
          prod_r <= prod;
          dcnt_r <= 6'd18;
        end else begin
          v_r[jj] <= a_r[jj] + VALUE_BITS'(prod_r >>> 16);
          jcnt_r <= jcnt_r + 4'd1;
          dcnt_r <= 6'd17;
        end
      end
      OP_COPY: begin
        for (int j = 0; j < NUM_VALUES; j++)
          v_r[j] <= stat.below_first ? val_mem[0][j] : val_mem[last_i][j];
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int j = 0; j < NUM_VALUES; j++)
      res_vals[j*IN_W +: IN_W] = IN_W'(v_r[j]);
  end
endmodule
`default_nettype wire

// ===== sv/kli_ctrl.sv =====
// Controller state machine: sequences insert shifting, search, divide, interpolate.
// Depends on kli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kli_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [1:0] in_mode,
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [1:0] out_status,
  output kli_pkg::cmd_t cmd,
  input  wire kli_pkg::stat_t stat
);
  import kli_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_WRITE, S_SRCH, S_FIND, S_DIV, S_INTERP, S_COPY, S_OUT
  } state_t;
  state_t state_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:
        if (in_tvalid) begin
          if (in_mode == MODE_CLEAR) cmd.op = OP_CLEAR;
          else if (in_mode == MODE_INSERT && !stat.full) cmd.op = OP_SRCH_LD;
          else if (in_mode == MODE_SAMPLE && !stat.empty) cmd.op = OP_SRCH_LD;
          else cmd.op = OP_ZERO;
        end
      S_SHIFT: cmd.op = stat.shift_done ? OP_NONE : OP_SHIFT;
      S_WRITE: cmd.op = OP_WRITE;
      S_SRCH: cmd.op = (stat.below_first || stat.above_last) ? OP_COPY : OP_LOAD_LO;
      S_FIND: cmd.op = OP_LOAD_HI;
      S_DIV: cmd.op = stat.div_done ? OP_NONE : OP_DIV;
      S_INTERP: cmd.op = OP_INTERP;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_tvalid <= 1'b0;
      out_status <= ST_STORED;
    end else begin
      case (state_r)
        S_IDLE:
          if (in_tvalid) begin
            case (in_mode)
              MODE_INSERT: begin
                if (stat.full) begin
                  out_status <= ST_FULL;
                  out_tvalid <= 1'b1;
                  state_r <= S_OUT;
                end else state_r <= S_SHIFT;
              end
              MODE_SAMPLE: begin
                if (stat.empty) begin
                  out_status <= ST_EMPTY;
                  out_tvalid <= 1'b1;
                  state_r <= S_OUT;
                end else state_r <= S_SRCH;
              end
              default: begin
                out_status <= ST_STORED;
                out_tvalid <= 1'b1;
                state_r <= S_OUT;
              end
            endcase
          end
        S_SHIFT: if (stat.shift_done) state_r <= S_WRITE;
        S_WRITE: begin
          out_status <= ST_STORED;
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_SRCH: state_r <= (stat.below_first || stat.above_last) ? S_COPY : S_FIND;
        S_FIND: if (stat.srch_done) state_r <= S_DIV;
        S_DIV: if (stat.div_done) state_r <= S_INTERP;
        S_INTERP: if (stat.interp_done) begin
          out_status <= ST_SAMPLED;
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_COPY: begin
          out_status <= ST_SAMPLED;
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          out_tvalid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/keyframe_linear_interpolator.sv =====
// From input accept to result: clear, table full, empty table and unused mode are
// answered directly; insert shifts the entries above the new key, then writes it;
// a sample at or beyond the ends copies an end keyframe; else search, 17-step divider,
// product and sum for each of nine values. One item at a time, next the cycle after.
// Reset (rst_n low, synchronous) empties the table and idles the controller.
// Top level of the keyframe interpolator; depends on kli_pkg, kli_ctrl, kli_datapath.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_linear_interpolator #(
  parameter int MAX_KEYFRAMES = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // mode[1:0], key_position[25:2], field_of_view .. pitch_angle 32 bits each from bit 26
  input  wire logic [319:0] in_tdata,
  output logic out_tvalid,
  input  wire logic out_tready,
  // status[1:0], out_field_of_view .. out_pitch_angle 32 bits each from bit 2
  output logic [295:0] out_tdata
);
  import kli_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic [1:0] status;
  logic [NUM_VALUES*IN_W-1:0] res_vals;

  kli_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_mode(in_tdata[1:0]),
    .out_tvalid, .out_tready, .out_status(status), .cmd, .stat
  );
  kli_datapath #(.MAX_KEYFRAMES(MAX_KEYFRAMES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_pos(in_tdata[25:2]),
    .in_vals(in_tdata[26 +: NUM_VALUES*IN_W]), .res_vals
  );
  assign out_tdata = {6'd0, res_vals, status};
endmodule
`default_nettype wire

// ===== sv/kli_checker.sv =====
// Port-level checker for the keyframe interpolator, bound to the top level.
// Depends on keyframe_linear_interpolator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_linear_interpolator_defines.svh"
module kli_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [295:0] out_tdata
);
  `KLI_ASSERT_IMPL(a_excl, out_tvalid, !in_tready)
  `KLI_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `KLI_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready)
  `KLI_ASSERT_IMPL(a_zero, out_tvalid && out_tdata[1:0] != 2'd0, out_tdata[295:2] == '0)
endmodule
bind keyframe_linear_interpolator kli_checker u_kli_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
